### hdl/rgb2hsv_pkg.sv
package rgb2hsv_pkg;

    localparam int CH_W      = 8;
    localparam int QUOT_W    = 8;
    localparam int REM_W     = 2 * CH_W;
    localparam int DEN_W     = CH_W + QUOT_W - 1;
    localparam int NUM_CELLS = QUOT_W;

    localparam logic [CH_W-1:0] HUE_STEP   = 8'd43;
    localparam logic [CH_W-1:0] BASE_RED   = 8'd0;
    localparam logic [CH_W-1:0] BASE_GREEN = 8'd85;
    localparam logic [CH_W-1:0] BASE_BLUE  = 8'd171;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic              gray;
        logic              neg;
        t_sector           sector;
        logic [CH_W-1:0]   value;
        logic [CH_W-1:0]   alpha;
        logic [REM_W-1:0]  sat_rem;
        logic [DEN_W-1:0]  sat_den;
        logic [QUOT_W-1:0] sat_q;
        logic [REM_W-1:0]  hue_rem;
        logic [DEN_W-1:0]  hue_den;
        logic [QUOT_W-1:0] hue_q;
    } t_div_item;

endpackage

### hdl/rgb2hsv_pix_if.sv
interface rgb2hsv_pix_if
    import rgb2hsv_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

### hdl/rgb2hsv_hsv_if.sv
interface rgb2hsv_hsv_if
    import rgb2hsv_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] hue_out;
    logic [CH_W-1:0] saturation_out;
    logic [CH_W-1:0] value_out;
    logic [CH_W-1:0] alpha_out;

    modport source (output valid, hue_out, saturation_out, value_out, alpha_out, input ready);
    modport sink (input valid, hue_out, saturation_out, value_out, alpha_out, output ready);
endinterface

### hdl/rgb2hsv_front.sv
module rgb2hsv_front
    import rgb2hsv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgb2hsv_pix_if.sink i_pix,
    output logic        o_valid,
    output t_div_item   o_item,
    input  logic        i_ready
);

    // stage 1: max, min, sector
    logic            r_v1;
    logic [CH_W-1:0] r_max;
    logic [CH_W-1:0] r_min;
    logic [CH_W-1:0] r_plus;
    logic [CH_W-1:0] r_minus;
    logic [CH_W-1:0] r_alpha;
    t_sector         r_sector;

    logic            n_v1_rdy;
    logic [CH_W-1:0] n_max;
    logic [CH_W-1:0] n_min;
    logic [CH_W-1:0] n_plus;
    logic [CH_W-1:0] n_minus;
    t_sector         n_sector;

    // stage 2: delta, dividends
    logic            r_v2;
    t_div_item       r_item;
    logic            n_v2_rdy;

    logic [CH_W-1:0]  s2_delta;
    logic             s2_neg;
    logic [CH_W-1:0]  s2_mag;
    t_div_item        n_item;

    assign n_v2_rdy    = !r_v2 || i_ready;
    assign n_v1_rdy    = !r_v1 || n_v2_rdy;
    assign i_pix.ready = n_v1_rdy;
    assign o_valid     = r_v2;
    assign o_item      = r_item;

    always_comb begin
        if (i_pix.red_in >= i_pix.green_in && i_pix.red_in >= i_pix.blue_in) begin
            n_sector = SEC_RED;
            n_max    = i_pix.red_in;
            n_plus   = i_pix.green_in;
            n_minus  = i_pix.blue_in;
        end else if (i_pix.green_in >= i_pix.blue_in) begin
            n_sector = SEC_GREEN;
            n_max    = i_pix.green_in;
            n_plus   = i_pix.blue_in;
            n_minus  = i_pix.red_in;
        end else begin
            n_sector = SEC_BLUE;
            n_max    = i_pix.blue_in;
            n_plus   = i_pix.red_in;
            n_minus  = i_pix.green_in;
        end
        n_min = i_pix.red_in;
        if (i_pix.green_in < n_min) begin
            n_min = i_pix.green_in;
        end
        if (i_pix.blue_in < n_min) begin
            n_min = i_pix.blue_in;
        end
    end

    always_comb begin
        s2_delta = r_max - r_min;
        s2_neg   = r_plus < r_minus;
        s2_mag   = s2_neg ? (r_minus - r_plus) : (r_plus - r_minus);

        n_item         = '0;
        n_item.gray    = (s2_delta == '0);
        n_item.neg     = s2_neg;
        n_item.sector  = r_sector;
        n_item.value   = r_max;
        n_item.alpha   = r_alpha;
        n_item.sat_rem = {s2_delta, {CH_W{1'b0}}} - {{CH_W{1'b0}}, s2_delta};
        n_item.sat_den = {r_max, {(QUOT_W-1){1'b0}}};
        n_item.hue_rem = {{CH_W{1'b0}}, s2_mag} * {{CH_W{1'b0}}, HUE_STEP};
        n_item.hue_den = {s2_delta, {(QUOT_W-1){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (n_v1_rdy) begin
                r_v1 <= i_pix.valid;
            end
            if (n_v2_rdy) begin
                r_v2 <= r_v1;
            end
        end
        if (n_v1_rdy && i_pix.valid) begin
            r_max    <= n_max;
            r_min    <= n_min;
            r_plus   <= n_plus;
            r_minus  <= n_minus;
            r_sector <= n_sector;
            r_alpha  <= i_pix.alpha_in;
        end
        if (n_v2_rdy && r_v1) begin
            r_item <= n_item;
        end
    end

endmodule

### hdl/rgb2hsv_div_cell.sv
module rgb2hsv_div_cell
    import rgb2hsv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_item i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_div_item o_item,
    input  logic      i_ready
);

    logic      r_valid;
    t_div_item r_item;
    t_div_item n_item;
    logic      sat_bit;
    logic      hue_bit;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // one restoring step for each divider
    always_comb begin
        n_item  = i_item;
        sat_bit = i_item.sat_rem >= {1'b0, i_item.sat_den};
        hue_bit = i_item.hue_rem >= {1'b0, i_item.hue_den};
        if (sat_bit) begin
            n_item.sat_rem = i_item.sat_rem - {1'b0, i_item.sat_den};
        end
        if (hue_bit) begin
            n_item.hue_rem = i_item.hue_rem - {1'b0, i_item.hue_den};
        end
        n_item.sat_den = i_item.sat_den >> 1;
        n_item.hue_den = i_item.hue_den >> 1;
        n_item.sat_q   = {i_item.sat_q[QUOT_W-2:0], sat_bit};
        n_item.hue_q   = {i_item.hue_q[QUOT_W-2:0], hue_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

### hdl/rgb2hsv_back.sv
module rgb2hsv_back
    import rgb2hsv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_div_item     i_item,
    output logic          o_ready,
    rgb2hsv_hsv_if.source o_hsv
);

    logic            r_valid;
    logic [CH_W-1:0] r_hue;
    logic [CH_W-1:0] r_sat;
    logic [CH_W-1:0] r_value;
    logic [CH_W-1:0] r_alpha;

    logic [CH_W-1:0] n_hue;
    logic [CH_W-1:0] n_sat;
    logic [CH_W-1:0] base;
    logic [CH_W-1:0] offs;

    assign o_ready              = !r_valid || o_hsv.ready;
    assign o_hsv.valid          = r_valid;
    assign o_hsv.hue_out        = r_hue;
    assign o_hsv.saturation_out = r_sat;
    assign o_hsv.value_out      = r_value;
    assign o_hsv.alpha_out      = r_alpha;

    always_comb begin
        unique case (i_item.sector)
            SEC_RED:   base = BASE_RED;
            SEC_GREEN: base = BASE_GREEN;
            SEC_BLUE:  base = BASE_BLUE;
            default:   base = BASE_RED;
        endcase
        offs  = i_item.neg ? (~i_item.hue_q + 1'b1) : i_item.hue_q;
        n_hue = i_item.gray ? '0 : (base + offs);
        n_sat = i_item.gray ? '0 : i_item.sat_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_value <= i_item.value;
            r_alpha <= i_item.alpha;
        end
    end

endmodule

### hdl/rgb2hsv_to_hsv_8bit.sv
// rgb_to_hsv_8bit: RGBA to HSV pixel converter, 8 bits per channel.
// Input channel i_pix carries red, green, blue and alpha; output channel
// o_hsv carries hue, saturation, value and the unchanged alpha. Both use a
// valid/ready handshake; a transaction completes when valid and ready are
// both high at a rising clock edge.
// A pixel passes from input transaction to o_hsv.valid through the min/max
// stage, the dividend setup stage, eight divider cells that each resolve
// one quotient bit of both divisions (saturation and hue), and one output
// register. Throughput is one pixel per clock unless o_hsv.ready stalls.
// Every stage holds its own valid bit and advances whenever the next stage
// is empty or moving, so bubbles close up and a waiting result in the
// output register does not stop new pixels from entering. When o_hsv.ready
// stays low the pipeline fills; i_pix.ready drops only once all 11 stages
// hold pixels.
// Reset (i_rst_n low, synchronous) clears all valid bits; pixels in flight
// are dropped.
module rgb_to_hsv_8bit
    import rgb2hsv_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgb2hsv_pix_if.sink   i_pix,
    rgb2hsv_hsv_if.source o_hsv
);

    logic      chain_valid [0:NUM_CELLS];
    logic      chain_ready [0:NUM_CELLS];
    t_div_item chain_item  [0:NUM_CELLS];

    rgb2hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_valid (chain_valid[0]),
        .o_item  (chain_item[0]),
        .i_ready (chain_ready[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        rgb2hsv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[k]),
            .i_item  (chain_item[k]),
            .o_ready (chain_ready[k]),
            .o_valid (chain_valid[k+1]),
            .o_item  (chain_item[k+1]),
            .i_ready (chain_ready[k+1])
        );
    end

    rgb2hsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[NUM_CELLS]),
        .i_item  (chain_item[NUM_CELLS]),
        .o_ready (chain_ready[NUM_CELLS]),
        .o_hsv   (o_hsv)
    );

endmodule

### bench/rgb_to_hsv_8bit_tb.sv
module rgb_to_hsv_8bit_tb;
    import rgb2hsv_pkg::*;

    localparam int LATENCY     = 11;
    localparam int HOLD_CYCLES = 200;
    localparam int FULL_SCALE  = 255;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PERIODIC
    } t_sink_mode;

    typedef struct packed {
        logic [CH_W-1:0] hue;
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] val;
        logic [CH_W-1:0] alpha;
    } t_hsv_px;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rgb2hsv_pix_if pix ();
    rgb2hsv_hsv_if hsv ();

    rgb_to_hsv_8bit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_hsv   (hsv)
    );

    t_hsv_px    hsv_expected[$];
    int         n_errors    = 0;
    int         burst_left  = 0;
    int         src_gap_max = 0;
    t_sink_mode sink_mode   = SINK_ALWAYS;
    logic       hold_req    = 1'b0;
    logic       hold_off    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_hsv_px hsv_of_pixel(input logic [CH_W-1:0] r, g, b, a);
        t_hsv_px         res;
        logic [CH_W-1:0] mx, mn, delta, base, plus, minus, offs;
        t_sector         sector;
        int unsigned     mag;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        res.val = mx;
        res.alpha = a;
        res.hue = '0;
        res.sat = '0;
        if (delta != 0) begin
            res.sat = CH_W'((FULL_SCALE * delta) / mx);
            if (r == mx) sector = SEC_RED;
            else if (g == mx) sector = SEC_GREEN;
            else sector = SEC_BLUE;
            case (sector)
                SEC_RED: begin
                    base = BASE_RED;
                    plus = g;
                    minus = b;
                end
                SEC_GREEN: begin
                    base = BASE_GREEN;
                    plus = b;
                    minus = r;
                end
                default: begin
                    base = BASE_BLUE;
                    plus = r;
                    minus = g;
                end
            endcase
            mag = (plus < minus) ? 32'(minus - plus) : 32'(plus - minus);
            // truncate toward zero, then wrap mod 256
            offs = CH_W'((HUE_STEP * mag) / delta);
            res.hue = (plus < minus) ? base - offs : base + offs;
        end
        return res;
    endfunction

    task automatic send_pixel(input logic [CH_W-1:0] r, g, b, a);
        int gap;
        pix.valid <= 1'b1;
        pix.red_in <= r;
        pix.green_in <= g;
        pix.blue_in <= b;
        pix.alpha_in <= a;
        do @(posedge i_clk); while (pix.ready !== 1'b1);
        hsv_expected.push_back(hsv_of_pixel(r, g, b, a));
        if (src_gap_max > 0) begin
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
                gap = $urandom_range(1, src_gap_max);
                pix.valid <= 1'b0;
                pix.red_in <= CH_W'($urandom);
                pix.green_in <= CH_W'($urandom);
                pix.blue_in <= CH_W'($urandom);
                pix.alpha_in <= CH_W'($urandom);
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    task automatic send_random_pixel();
        logic [CH_W-1:0] r, g, b, hi, lo;
        int              kind, pick, d;
        kind = $urandom_range(0, 9);
        hi = CH_W'($urandom);
        lo = CH_W'($urandom_range(0, hi));
        r = CH_W'($urandom);
        g = CH_W'($urandom);
        b = CH_W'($urandom);
        case (kind)
            0: begin
                r = hi;
                g = hi;
                b = hi;
            end
            1: begin
                pick = $urandom_range(0, 2);
                r = (pick == 1) ? lo : hi;
                g = (pick == 2) ? lo : hi;
                b = (pick == 0) ? lo : hi;
            end
            2: begin
                d = (hi < 3) ? int'(hi) : 3;
                r = hi - CH_W'($urandom_range(0, d));
                g = hi - CH_W'($urandom_range(0, d));
                b = hi - CH_W'($urandom_range(0, d));
            end
            default: ;
        endcase
        send_pixel(r, g, b, CH_W'($urandom));
    endtask

    task automatic wait_drained();
        pix.valid <= 1'b0;
        while (hsv_expected.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // receiver: stall pattern, overridden by a long hold-off
    initial begin
        int cyc;
        cyc = 0;
        hsv.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_off) hsv.ready <= 1'b0;
            else case (sink_mode)
                SINK_ALWAYS:   hsv.ready <= 1'b1;
                SINK_RANDOM:   hsv.ready <= ($urandom_range(0, 99) >= 30);
                SINK_PERIODIC: hsv.ready <= ((cyc % 7) >= 3);
                default:       hsv.ready <= 1'b1;
            endcase
        end
    end

    initial begin
        forever begin
            wait (hold_req);
            @(posedge i_clk);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off <= 1'b0;
            hold_req = 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_hsv_px got, want;
        if (hsv.valid === 1'b1 && hsv.ready === 1'b1) begin
            got = '{hsv.hue_out, hsv.saturation_out, hsv.value_out, hsv.alpha_out};
            if (hsv_expected.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("unexpected transaction: h %0d s %0d v %0d a %0d",
                             got.hue, got.sat, got.val, got.alpha);
            end else begin
                want = hsv_expected.pop_front();
                if (got.hue !== want.hue || got.sat !== want.sat ||
                    got.val !== want.val || got.alpha !== want.alpha) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.hue, want.sat, want.val, want.alpha,
                                 got.hue, got.sat, got.val, got.alpha);
                end
            end
        end
    end

    task automatic test_directed();
        sink_mode = SINK_ALWAYS;
        src_gap_max = 0;
        send_pixel(8'd0,   8'd0,   8'd0,   8'h00);
        send_pixel(8'd255, 8'd255, 8'd255, 8'hFF);
        send_pixel(8'd128, 8'd128, 8'd128, 8'h5A);
        send_pixel(8'd255, 8'd0,   8'd0,   8'hA5);
        send_pixel(8'd0,   8'd255, 8'd0,   8'h00);
        send_pixel(8'd0,   8'd0,   8'd255, 8'hFF);
        // negative offsets in each sector
        send_pixel(8'd255, 8'd0,   8'd10,  8'h12);
        send_pixel(8'd10,  8'd255, 8'd0,   8'h34);
        send_pixel(8'd0,   8'd10,  8'd255, 8'h56);
        send_pixel(8'd200, 8'd3,   8'd199, 8'h78);
        // ties for the maximum
        send_pixel(8'd200, 8'd200, 8'd50,  8'h9A);
        send_pixel(8'd200, 8'd50,  8'd200, 8'hBC);
        send_pixel(8'd50,  8'd200, 8'd200, 8'hDE);
        send_pixel(8'd255, 8'd255, 8'd0,   8'hF0);
        send_pixel(8'd0,   8'd255, 8'd255, 8'h0F);
        send_pixel(8'd255, 8'd0,   8'd255, 8'h81);
        // tiny delta, tiny max
        send_pixel(8'd255, 8'd254, 8'd254, 8'h7E);
        send_pixel(8'd1,   8'd0,   8'd0,   8'h01);
        send_pixel(8'd0,   8'd1,   8'd0,   8'h02);
        send_pixel(8'd0,   8'd0,   8'd1,   8'h04);
        send_pixel(8'd1,   8'd1,   8'd1,   8'h08);
        send_pixel(8'd254, 8'd1,   8'd128, 8'h55);
        wait_drained();
    endtask

    task automatic test_random_mix(input int n_items, input int gap_max);
        sink_mode = SINK_RANDOM;
        src_gap_max = gap_max;
        repeat (n_items) send_random_pixel();
    endtask

    task automatic test_full_rate(input int n_items);
        sink_mode = SINK_ALWAYS;
        src_gap_max = 0;
        repeat (n_items) send_random_pixel();
    endtask

    task automatic test_periodic_sink(input int n_items);
        sink_mode = SINK_PERIODIC;
        src_gap_max = 4;
        repeat (n_items) send_random_pixel();
    endtask

    task automatic test_backpressure(input int n_items);
        sink_mode = SINK_ALWAYS;
        src_gap_max = 0;
        hold_req = 1'b1;
        repeat (n_items) send_random_pixel();
    endtask

    task automatic test_drain_pause(input int n_items);
        sink_mode = SINK_RANDOM;
        src_gap_max = 6;
        repeat (n_items) send_random_pixel();
        wait_drained();
        repeat (n_items) send_random_pixel();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        pix.valid <= 1'b0;
        pix.red_in <= '0;
        pix.green_in <= '0;
        pix.blue_in <= '0;
        pix.alpha_in <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_mix(600, 12);
        test_full_rate(300);
        test_periodic_sink(250);
        test_backpressure(100);
        test_drain_pause(60);
        test_random_mix(300, 3);

        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
